>>> sv/mwsm_pkg.sv
// mwsm_pkg: sizes and register codes for the masked window sum max block
// no dependencies
`default_nettype none

package mwsm_pkg;

  localparam int MAX_WINDOW = 1024;
  localparam int VALUE_BITS = 16;
  localparam int WIN_AW     = $clog2(MAX_WINDOW);
  localparam int FILL_W     = WIN_AW + 1;
  localparam int WSUM_W     = VALUE_BITS + WIN_AW + 1;
  localparam int SUM_W      = 48;
  localparam int CFG_LEN_W  = 11;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam int REG_IDX_W  = PADDR_W - 2;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_WINDOW_LENGTH = reg_idx_t'(0);

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

endpackage

`default_nettype wire

>>> sv/masked_window_sum_max_top.sv
// masked_window_sum_max_top: awake total plus best sliding window sum per sequence
// depends on mwsm_pkg; holds the ring buffer memory, input stage and result register
//
//   channel  | direction | handshake              | payload
//   in       | to block  | in_valid / in_ready    | in_value, in_awake, in_last
//   out      | from block| out_valid / out_ready  | out_best_total
//   cfg      | to block  | psel/penable/pready    | paddr, pwdata, prdata
//
// one transfer per cycle in unless stalled, result registered as a last item leaves s1
// the ring buffer read is issued at the input transfer, data registered with the item
// reset is synchronous on rst_n, no memory clearing pass
// an item with last stalls only while the result register is full and not taken
`default_nettype none

module masked_window_sum_max_top
  import mwsm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [VALUE_BITS-1:0] in_value,
  input  wire logic                  in_awake,
  input  wire logic                  in_last,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [SUM_W-1:0]           out_best_total,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]         prdata,
  output logic                       pready
);

  logic [CFG_LEN_W-1:0]  cfg_len_r;
  logic [FILL_W-1:0]     len_eff;
  logic                  cfg_wr;
  reg_idx_t              reg_idx;

  logic [VALUE_BITS-1:0] win_mem [MAX_WINDOW];
  logic [WIN_AW-1:0]     wp_r, wp_nxt, rd_addr;

  logic                  s1_valid_r, s1_valid_nxt;
  logic [VALUE_BITS-1:0] s1_value_r;
  logic                  s1_awake_r;
  logic                  s1_last_r;
  logic [VALUE_BITS-1:0] s1_old_r;

  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [WSUM_W-1:0]     wsum_r, wsum_nxt;
  logic [WSUM_W-1:0]     best_r, best_nxt;
  logic [SUM_W-1:0]      awake_r, awake_nxt;
  logic                  out_valid_r;
  logic [SUM_W-1:0]      out_r;

  logic                  in_xfer, s1_adv, drop_old;
  logic [VALUE_BITS-1:0] masked_in, s1_masked;
  logic [SUM_W:0]        awake_add, total_add;
  logic [SUM_W-1:0]      total_sat;

  // config port
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && (reg_idx == REG_WINDOW_LENGTH);

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_WINDOW_LENGTH) begin
      prdata = PDATA_W'(cfg_len_r);
    end
  end

  always_comb begin
    if (cfg_len_r == '0) begin
      len_eff = FILL_W'(1);
    end else if (FILL_W'(cfg_len_r) > FILL_W'(MAX_WINDOW)) begin
      len_eff = FILL_W'(MAX_WINDOW);
    end else begin
      len_eff = FILL_W'(cfg_len_r);
    end
  end

  // input stage and ring buffer
  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_xfer   = in_valid && in_ready;
  assign masked_in = in_awake ? '0 : in_value;
  assign rd_addr   = wp_r - len_eff[WIN_AW-1:0];

  always_comb begin
    wp_nxt = wp_r;
    if (in_xfer) begin
      wp_nxt = in_last ? '0 : wp_r + WIN_AW'(1);
    end
    s1_valid_nxt = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_old_r        <= win_mem[rd_addr];
      win_mem[wp_r]   <= masked_in;
      s1_value_r      <= in_value;
      s1_awake_r      <= in_awake;
      s1_last_r       <= in_last;
    end
  end

  // window update
  assign s1_masked = s1_awake_r ? '0 : s1_value_r;
  assign drop_old  = (fill_r >= len_eff);
  assign awake_add = {1'b0, awake_r} + (SUM_W+1)'(s1_value_r);

  always_comb begin
    fill_nxt  = drop_old ? len_eff : fill_r + FILL_W'(1);
    wsum_nxt  = wsum_r - (drop_old ? WSUM_W'(s1_old_r) : '0) + WSUM_W'(s1_masked);
    awake_nxt = awake_r;
    if (s1_awake_r) begin
      awake_nxt = awake_add[SUM_W] ? SUM_MAX : awake_add[SUM_W-1:0];
    end
    best_nxt  = (wsum_nxt > best_r) ? wsum_nxt : best_r;
    total_add = {1'b0, awake_nxt} + (SUM_W+1)'(best_nxt);
    total_sat = total_add[SUM_W] ? SUM_MAX : total_add[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r   <= CFG_LEN_W'(1);
      wp_r        <= '0;
      s1_valid_r  <= 1'b0;
      fill_r      <= '0;
      wsum_r      <= '0;
      best_r      <= '0;
      awake_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r       <= wp_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        if (s1_last_r) begin
          fill_r      <= '0;
          wsum_r      <= '0;
          best_r      <= '0;
          awake_r     <= '0;
          out_valid_r <= 1'b1;
        end else begin
          fill_r  <= fill_nxt;
          wsum_r  <= wsum_nxt;
          best_r  <= best_nxt;
          awake_r <= awake_nxt;
        end
      end
      if (cfg_wr) begin
        cfg_len_r <= pwdata[CFG_LEN_W-1:0];
        wp_r      <= '0;
        fill_r    <= '0;
        wsum_r    <= '0;
        best_r    <= '0;
        awake_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_r <= total_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_best_total = out_r;

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= len_eff)
    else $error("fill count above window length");

  a_best_covers_sum: assert property (@(posedge clk) disable iff (!rst_n)
    wsum_r <= best_r)
    else $error("window sum above best window");

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> fill_r == '0 && wsum_r == '0 && best_r == '0 && awake_r == '0)
    else $error("sequence state not cleared after last");

  a_stall_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_last_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while last item is blocked");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for masked_window_sum_max_top, needs mwsm_pkg and the block
// keeps its own copy of the window state, predicts each sequence's best total and checks
// every output transfer against it under random idling, long back-pressure and reconfiguration
module tb_top
  import mwsm_pkg::*;
;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  awake;
    logic                  last;
  } position_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  localparam reg_idx_t REG_SPARE     = reg_idx_t'(1);
  localparam int       HOLD_CYCLES   = 300;
  localparam int       DRAIN_LIMIT   = 20000;
  localparam int       SETTLE_CYCLES = 8;

  logic                  clk;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [VALUE_BITS-1:0] in_value       = '0;
  logic                  in_awake       = 1'b0;
  logic                  in_last        = 1'b0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [SUM_W-1:0]      out_best_total;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [PADDR_W-1:0]    paddr          = '0;
  logic [PDATA_W-1:0]    pwdata         = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  // predicted block state
  logic [VALUE_BITS-1:0] ring_mem [MAX_WINDOW];
  logic [WIN_AW-1:0]     ring_wptr   = '0;
  logic [FILL_W-1:0]     ring_fill   = '0;
  logic [WSUM_W-1:0]     run_sum     = '0;
  logic [WSUM_W-1:0]     peak_sum    = '0;
  logic [SUM_W-1:0]      awake_total = '0;
  logic [CFG_LEN_W-1:0]  cfg_len     = CFG_LEN_W'(1);

  position_t        positions_q [$];
  logic [SUM_W-1:0] best_totals_q [$];
  position_t        next_pos;
  logic [SUM_W-1:0] want_total;
  int               tx_idle_pct  = 0;
  int               rx_stall_pct = 0;
  logic             hold_rx      = 1'b0;
  int               mismatches   = 0;

  masked_window_sum_max_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_awake       (in_awake),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_best_total (out_best_total),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  function automatic int window_span(logic [CFG_LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > MAX_WINDOW) return MAX_WINDOW;
    return int'(len);
  endfunction

  function automatic logic [SUM_W-1:0] sat_add48(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = a + b;
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  task automatic restart_sequence();
    ring_wptr   = '0;
    ring_fill   = '0;
    run_sum     = '0;
    peak_sum    = '0;
    awake_total = '0;
  endtask

  task automatic predict_best_total(position_t pos);
    int                    span;
    logic [VALUE_BITS-1:0] masked;
    logic [WIN_AW-1:0]     oldest;
    span   = window_span(cfg_len);
    masked = pos.awake ? '0 : pos.value;
    if (ring_fill >= span) begin
      oldest    = ring_wptr - WIN_AW'(span);
      run_sum   = run_sum - ring_mem[oldest];
      ring_fill = FILL_W'(span);
    end else begin
      ring_fill = ring_fill + 1'b1;
    end
    run_sum             = run_sum + masked;
    ring_mem[ring_wptr] = masked;
    ring_wptr           = ring_wptr + 1'b1;
    if (pos.awake) awake_total = sat_add48(awake_total, SUM_W'(pos.value));
    if (run_sum > peak_sum) peak_sum = run_sum;
    if (pos.last) begin
      best_totals_q = {best_totals_q, sat_add48(awake_total, SUM_W'(peak_sum))};
      restart_sequence();
    end
  endtask

  // input driver, prediction taken at each input transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_best_total(position_t'({in_value, in_awake, in_last}));
      if (!in_valid || in_ready) begin
        if (positions_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          next_pos = positions_q.pop_front();
          in_valid <= 1'b1;
          in_value <= next_pos.value;
          in_awake <= next_pos.awake;
          in_last  <= next_pos.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (best_totals_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer best_total=%0d", out_best_total));
        end else begin
          want_total = best_totals_q.pop_front();
          if (out_best_total !== want_total)
            report_mismatch($sformatf("best_total got %0d want %0d", out_best_total, want_total));
        end
      end
      out_ready <= !hold_rx && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        tx_idle_pct = 0; rx_stall_pct = 0;
      end
      IDLE_SENDER: begin
        tx_idle_pct = 53; rx_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        tx_idle_pct = 0; rx_stall_pct = 53;
      end
      default: begin
        tx_idle_pct = 30; rx_stall_pct = 30;
      end
    endcase
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [PDATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_WINDOW_LENGTH) begin
      cfg_len = data[CFG_LEN_W-1:0];
      restart_sequence();
    end
  endtask

  task automatic add_pos(logic [VALUE_BITS-1:0] value, logic awake, logic last);
    position_t pos;
    pos.value = value;
    pos.awake = awake;
    pos.last  = last;
    positions_q = {positions_q, pos};
  endtask

  function automatic logic [VALUE_BITS-1:0] rand_value();
    case ($urandom_range(9))
      0, 1:    return '0;
      2, 3:    return '1;
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  task automatic push_sequence(int n, logic close);
    for (int i = 0; i < n; i++)
      add_pos(rand_value(), $urandom_range(99) < 30, close && (i == n - 1));
  endtask

  // waits for every queued item and every expected transfer, then lets the pipeline settle
  task automatic wait_drained();
    int waited;
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while ((positions_q.size() != 0 || in_valid || best_totals_q.size() != 0)
               && waited < DRAIN_LIMIT);
    if (best_totals_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected transfers never came", best_totals_q.size()));
      best_totals_q.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [CFG_LEN_W-1:0] len_plan [8];
    int                   span;
    int                   n;
    int                   budget;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    set_idling(IDLE_NONE);

    // reset length is one
    add_pos('1, 1'b0, 1'b1);
    add_pos('1, 1'b1, 1'b1);
    add_pos('0, 1'b0, 1'b1);
    add_pos('0, 1'b1, 1'b0);
    add_pos('1, 1'b1, 1'b0);
    add_pos(VALUE_BITS'(1), 1'b0, 1'b1);
    wait_drained();
    // zero length acts as one
    cfg_write(REG_WINDOW_LENGTH, '0);
    add_pos(VALUE_BITS'(5), 1'b0, 1'b0);
    add_pos(VALUE_BITS'(7), 1'b0, 1'b0);
    add_pos('1, 1'b1, 1'b1);
    wait_drained();
    cfg_write(REG_WINDOW_LENGTH, PDATA_W'(3));
    add_pos('1, 1'b0, 1'b0);
    add_pos('1, 1'b0, 1'b0);
    add_pos('1, 1'b0, 1'b0);
    add_pos(VALUE_BITS'(100), 1'b1, 1'b0);
    add_pos(VALUE_BITS'(1), 1'b0, 1'b0);
    add_pos('1, 1'b0, 1'b1);
    wait_drained();
    // length above the store depth saturates
    cfg_write(REG_WINDOW_LENGTH, PDATA_W'(2047));
    add_pos('1, 1'b0, 1'b0);
    add_pos('1, 1'b0, 1'b0);
    add_pos(VALUE_BITS'(3), 1'b1, 1'b1);
    wait_drained();
    // write to an unused address leaves an open sequence alone
    cfg_write(REG_WINDOW_LENGTH, PDATA_W'(2));
    add_pos(VALUE_BITS'(9), 1'b0, 1'b0);
    add_pos(VALUE_BITS'(9), 1'b0, 1'b0);
    wait_drained();
    cfg_write(REG_SPARE, PDATA_W'(7));
    add_pos(VALUE_BITS'(1), 1'b0, 1'b1);
    wait_drained();
    // length write drops an open sequence
    add_pos(VALUE_BITS'(500), 1'b0, 1'b0);
    wait_drained();
    cfg_write(REG_WINDOW_LENGTH, 32'hFFFF_F401);
    add_pos(VALUE_BITS'(4), 1'b0, 1'b1);
    wait_drained();

    len_plan = '{CFG_LEN_W'(1), CFG_LEN_W'(0), CFG_LEN_W'(2), CFG_LEN_W'(MAX_WINDOW),
                 CFG_LEN_W'(2047), CFG_LEN_W'($urandom_range(3, 64)),
                 CFG_LEN_W'($urandom_range(1, MAX_WINDOW - 1)), CFG_LEN_W'(1025)};
    for (int p = 0; p < 8; p++) begin
      cfg_write(REG_WINDOW_LENGTH, {(PDATA_W-CFG_LEN_W)'($urandom), len_plan[p]});
      @(negedge clk);
      set_idling(idle_mode_t'(p % 4));
      span = window_span(len_plan[p]);
      if (p == 0) hold_rx = 1'b1;
      if (p == 3) begin
        // one sequence long enough to wrap the store at full length
        push_sequence(MAX_WINDOW + 80, 1'b1);
      end else begin
        budget = 0;
        while (budget < 70) begin
          if (p == 0) n = $urandom_range(1, 4);
          else n = $urandom_range(1, (span < 16) ? 3 * span + 4 : 48);
          push_sequence(n, 1'b1);
          budget += n;
        end
      end
      if (p == 0) begin
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rx = 1'b0;
      end
      if (p % 2 == 1) push_sequence($urandom_range(1, 10), 1'b0);
      wait_drained();
    end

    set_idling(IDLE_NONE);
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
